// ===== src/shid_pkg.sv =====
// ----------------------------------------------------------------------------
// shid_pkg
// Shared types and codes for the shared interrupt line dispatcher.
// ----------------------------------------------------------------------------
package shid_pkg;

  // item operation codes
  localparam logic [2:0] MODE_RAISE    = 3'd0;
  localparam logic [2:0] MODE_ATTACH   = 3'd1;
  localparam logic [2:0] MODE_DETACH   = 3'd2;
  localparam logic [2:0] MODE_ACK      = 3'd3;
  localparam logic [2:0] MODE_COMPLETE = 3'd4;

  // end-of-interrupt kinds
  localparam logic [1:0] EOI_NONE   = 2'd0;
  localparam logic [1:0] EOI_MASTER = 2'd1;
  localparam logic [1:0] EOI_BOTH   = 2'd2;
  localparam logic [1:0] EOI_APIC   = 2'd3;

  // complete outcomes
  localparam logic [1:0] OUT_CLAIMED  = 2'd0;
  localparam logic [1:0] OUT_PASSED   = 2'd1;
  localparam logic [1:0] OUT_DECLINED = 2'd2;

  // fixed lines
  localparam logic [4:0] TIMER_LINE   = 5'd0;
  localparam int         CASCADE_LINE = 2;
  localparam logic [4:0] LAST_MASTER  = 5'd7;

  // sequencer states
  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_DEC  = 10'b0000000010,
    S_MOD  = 10'b0000000100,
    S_RD   = 10'b0000001000,
    S_CHK  = 10'b0000010000,
    S_SRD  = 10'b0000100000,
    S_SCMP = 10'b0001000000,
    S_HRD  = 10'b0010000000,
    S_HWR  = 10'b0100000000,
    S_FIX  = 10'b1000000000
  } state_t;

endpackage

// ===== src/shid_ram.sv =====
// ----------------------------------------------------------------------------
// shid_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module shid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/shid_mod.sv =====
// ----------------------------------------------------------------------------
// shid_mod
// Iterative remainder unit: one compare and subtract per cycle.
// ----------------------------------------------------------------------------
module shid_mod #(
  parameter int SW = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [SW-1:0] value,
  input  logic [SW-1:0] divisor,
  output logic          done,
  output logic [SW-1:0] rem
);

  logic          run;
  logic [SW-1:0] acc;
  logic [SW-1:0] div;

  // run flag
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
    end else if (start) begin
      run <= 1'b1;
    end else if (run && (acc < div)) begin
      run <= 1'b0;
    end
  end

  // working value, reduced until below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= value;
      div <= divisor;
    end else if (run && (acc >= div)) begin
      acc <= acc - div;
    end
  end

  assign done = run && (acc < div);
  assign rem  = acc;

endmodule

// ===== src/shared_irq_handler_dispatch_core.sv =====
// ----------------------------------------------------------------------------
// shared_irq_handler_dispatch_core
// Dispatches interrupt raises to attached handlers, round robin on decline.
//
//   channel   signals                                   direction
//   command   start/busy, mode line handler_id declined  in
//   result    done, status wake_valid wake_id outcome    out
//             eoi spurious line_enabled
//   config    cfg_write, cfg_data (use_apic)             in
//
// An item is taken when start is high and busy is low; busy stays high until
// the item finishes, and done pulses for one cycle with the result.
// Attach and items rejected at decode (bad line or mode, empty list) finish
// in the decode state; raise runs the remainder unit, then a list read, or
// finishes at decode on the timer line or an empty line; acknowledge and
// complete take (offset + claimer) mod count in the remainder unit, then
// read the list, with one more read for a pass on decline; detach reads
// and moves entries one at a time (one RAM port), then fixes the counters.
// Reset clears all per-line counters and enables only the cascade line.
// The receiver cannot stall results.
// ----------------------------------------------------------------------------
module shared_irq_handler_dispatch_core #(
  parameter int LINES        = 24,
  parameter int MAX_HANDLERS = 8,
  parameter int ID_BITS      = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       cfg_write,
  input  logic       cfg_data,
  input  logic [2:0] mode,
  input  logic [4:0] line,
  input  logic [7:0] handler_id,
  input  logic       declined,
  output logic       done,
  output logic       status,
  output logic       wake_valid,
  output logic [7:0] wake_id,
  output logic [1:0] outcome,
  output logic [1:0] eoi,
  output logic       spurious,
  output logic       line_enabled
);

  localparam int LW    = $clog2(LINES);
  localparam int CW    = $clog2(MAX_HANDLERS + 1);
  localparam int PW    = (MAX_HANDLERS > 1) ? $clog2(MAX_HANDLERS) : 1;
  localparam int SW    = CW + 1;
  localparam int DEPTH = LINES * MAX_HANDLERS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [LINES-1:0] EN_RESET = LINES'(1) << shid_pkg::CASCADE_LINE;

  shid_pkg::state_t state, state_next;

  logic               use_apic;
  logic [2:0]         mode_r;
  logic [4:0]         line_r;
  logic [ID_BITS-1:0] id_r;
  logic               decl_r;

  logic [CW-1:0]      cnt_a [LINES];
  logic [CW-1:0]      off_a [LINES];
  logic [PW-1:0]      clm_a [LINES];
  logic [LINES-1:0]   en, en_next;

  logic [PW-1:0]      rd_pos, rd_pos_next;
  logic               pass_r, pass_next;

  logic [6:0]         line_ext;
  logic               line_ok;
  logic [LW-1:0]      idx;
  logic [CW-1:0]      cnt_c, off_c, off_inc, cnt_dec;
  logic [PW-1:0]      clm_c;
  logic [SW-1:0]      cnt1, pos_inc;
  logic [AW-1:0]      base;
  logic [15:0]        hid16, rd16;
  logic [ID_BITS-1:0] id_in;
  logic [1:0]         eoi_kind;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [ID_BITS-1:0] ram_wdata, rdata;

  logic               mod_start, mod_done;
  logic [SW-1:0]      mod_value, mod_rem;

  logic               cnt_we, off_we, clm_we;
  logic [CW-1:0]      cnt_wd, off_wd;
  logic [PW-1:0]      clm_wd;

  logic               fin;
  logic               st_n, wv_n, sp_n, le_n;
  logic [7:0]         wid_n;
  logic [1:0]         oc_n, eoi_n;

  // addressed line and its per-line state
  assign line_ext = {2'b00, line_r};
  assign line_ok  = line_ext < 7'(LINES);
  assign idx      = line_ext[LW-1:0];
  assign cnt_c    = cnt_a[idx];
  assign off_c    = off_a[idx];
  assign clm_c    = clm_a[idx];
  assign cnt1     = SW'(cnt_c);
  assign pos_inc  = SW'(rd_pos) + SW'(1);
  assign off_inc  = (off_c < CW'(MAX_HANDLERS)) ? off_c + CW'(1) : off_c;
  assign cnt_dec  = cnt_c - CW'(1);
  assign base     = AW'(idx) * AW'(MAX_HANDLERS);
  assign hid16    = 16'(handler_id);
  assign id_in    = hid16[ID_BITS-1:0];
  assign rd16     = 16'(rdata);
  assign eoi_kind = use_apic ? shid_pkg::EOI_APIC :
                    (line_r > shid_pkg::LAST_MASTER) ? shid_pkg::EOI_BOTH
                                                     : shid_pkg::EOI_MASTER;
  assign busy      = (state != shid_pkg::S_IDLE);
  assign ram_raddr = base + AW'(rd_pos);

  // handler lists, one row per line
  shid_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // shared remainder unit for list positions
  shid_mod #(
    .SW (SW)
  ) u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (mod_start),
    .value   (mod_value),
    .divisor (cnt1),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  // sequencer
  always_comb begin
    state_next  = state;
    ram_we      = 1'b0;
    ram_waddr   = base + AW'(cnt_c);
    ram_wdata   = id_r;
    mod_start   = 1'b0;
    mod_value   = SW'(off_c) + SW'(clm_c);
    cnt_we      = 1'b0;
    off_we      = 1'b0;
    clm_we      = 1'b0;
    cnt_wd      = cnt_c;
    off_wd      = off_c;
    clm_wd      = clm_c;
    en_next     = en;
    rd_pos_next = rd_pos;
    pass_next   = pass_r;
    fin         = 1'b0;
    st_n        = 1'b1;
    wv_n        = 1'b0;
    wid_n       = 8'd0;
    oc_n        = shid_pkg::OUT_CLAIMED;
    eoi_n       = shid_pkg::EOI_NONE;
    sp_n        = 1'b0;
    case (state)
      shid_pkg::S_IDLE: begin
        if (start) begin
          state_next = shid_pkg::S_DEC;
        end
      end
      shid_pkg::S_DEC: begin
        if (!line_ok || (mode_r > shid_pkg::MODE_COMPLETE)) begin
          fin = 1'b1;
        end else begin
          case (mode_r)
            shid_pkg::MODE_RAISE: begin
              if (line_r == shid_pkg::TIMER_LINE) begin
                st_n  = 1'b0;
                eoi_n = use_apic ? shid_pkg::EOI_APIC : shid_pkg::EOI_MASTER;
                fin   = 1'b1;
              end else begin
                off_we = 1'b1;
                off_wd = '0;
                if (cnt_c == '0) begin
                  st_n = 1'b0;
                  sp_n = 1'b1;
                  fin  = 1'b1;
                end else begin
                  mod_start  = 1'b1;
                  mod_value  = SW'(clm_c);
                  pass_next  = 1'b0;
                  state_next = shid_pkg::S_MOD;
                end
              end
            end
            shid_pkg::MODE_ATTACH: begin
              fin = 1'b1;
              if (cnt_c < CW'(MAX_HANDLERS)) begin
                ram_we = 1'b1;
                cnt_we = 1'b1;
                cnt_wd = cnt_c + CW'(1);
                if (cnt_c == '0) begin
                  en_next[idx] = 1'b1;
                end
                st_n = 1'b0;
              end
            end
            shid_pkg::MODE_DETACH: begin
              if (cnt_c == '0) begin
                fin = 1'b1;
              end else begin
                rd_pos_next = '0;
                state_next  = shid_pkg::S_SRD;
              end
            end
            default: begin
              // acknowledge and complete look up the current handler
              if (cnt_c == '0) begin
                fin = 1'b1;
              end else begin
                mod_start  = 1'b1;
                pass_next  = 1'b0;
                state_next = shid_pkg::S_MOD;
              end
            end
          endcase
        end
      end
      shid_pkg::S_MOD: begin
        if (mod_done) begin
          rd_pos_next = mod_rem[PW-1:0];
          state_next  = shid_pkg::S_RD;
        end
      end
      shid_pkg::S_RD: begin
        state_next = shid_pkg::S_CHK;
      end
      shid_pkg::S_CHK: begin
        if (pass_r) begin
          st_n  = 1'b0;
          wv_n  = 1'b1;
          wid_n = rd16[7:0];
          oc_n  = shid_pkg::OUT_PASSED;
          fin   = 1'b1;
        end else begin
          case (mode_r)
            shid_pkg::MODE_RAISE: begin
              st_n  = 1'b0;
              wv_n  = 1'b1;
              wid_n = rd16[7:0];
              fin   = 1'b1;
            end
            shid_pkg::MODE_ACK: begin
              fin = 1'b1;
              if (rdata == id_r) begin
                st_n  = 1'b0;
                eoi_n = eoi_kind;
              end
            end
            default: begin
              if (rdata != id_r) begin
                fin = 1'b1;
              end else if (!decl_r) begin
                clm_we = 1'b1;
                clm_wd = rd_pos;
                st_n   = 1'b0;
                fin    = 1'b1;
              end else begin
                off_we = 1'b1;
                off_wd = off_inc;
                if (SW'(off_inc) < cnt1) begin
                  // pass on to the next handler in the list
                  rd_pos_next = (pos_inc == cnt1) ? '0 : pos_inc[PW-1:0];
                  pass_next   = 1'b1;
                  state_next  = shid_pkg::S_RD;
                end else begin
                  st_n = 1'b0;
                  oc_n = shid_pkg::OUT_DECLINED;
                  fin  = 1'b1;
                end
              end
            end
          endcase
        end
      end
      shid_pkg::S_SRD: begin
        state_next = shid_pkg::S_SCMP;
      end
      shid_pkg::S_SCMP: begin
        // search for the first matching entry
        if (rdata == id_r) begin
          if (pos_inc < cnt1) begin
            rd_pos_next = pos_inc[PW-1:0];
            state_next  = shid_pkg::S_HRD;
          end else begin
            state_next = shid_pkg::S_FIX;
          end
        end else if (pos_inc < cnt1) begin
          rd_pos_next = pos_inc[PW-1:0];
          state_next  = shid_pkg::S_SRD;
        end else begin
          fin = 1'b1;
        end
      end
      shid_pkg::S_HRD: begin
        state_next = shid_pkg::S_HWR;
      end
      shid_pkg::S_HWR: begin
        // move the entry one place down
        ram_we    = 1'b1;
        ram_waddr = base + AW'(rd_pos) - AW'(1);
        ram_wdata = rdata;
        if (pos_inc < cnt1) begin
          rd_pos_next = pos_inc[PW-1:0];
          state_next  = shid_pkg::S_HRD;
        end else begin
          state_next = shid_pkg::S_FIX;
        end
      end
      shid_pkg::S_FIX: begin
        cnt_we = 1'b1;
        cnt_wd = cnt_dec;
        if ((off_c >= cnt_dec) && (off_c != '0)) begin
          off_we = 1'b1;
          off_wd = off_c - CW'(1);
        end
        if ((SW'(clm_c) >= SW'(cnt_dec)) && (clm_c != '0)) begin
          clm_we = 1'b1;
          clm_wd = clm_c - PW'(1);
        end
        if (cnt_dec == '0) begin
          en_next[idx] = 1'b0;
        end
        st_n = 1'b0;
        fin  = 1'b1;
      end
      default: begin
        state_next = shid_pkg::S_IDLE;
      end
    endcase
    if (fin) begin
      state_next = shid_pkg::S_IDLE;
    end
  end

  assign le_n = line_ok ? en_next[idx] : 1'b0;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= shid_pkg::S_IDLE;
      use_apic <= 1'b0;
      en       <= EN_RESET;
      done     <= 1'b0;
      pass_r   <= 1'b0;
      for (int i = 0; i < LINES; i++) begin
        cnt_a[i] <= '0;
        off_a[i] <= '0;
        clm_a[i] <= '0;
      end
    end else begin
      state  <= state_next;
      en     <= en_next;
      done   <= fin;
      pass_r <= pass_next;
      if (cfg_write) begin
        use_apic <= cfg_data;
      end
      if (cnt_we) begin
        cnt_a[idx] <= cnt_wd;
      end
      if (off_we) begin
        off_a[idx] <= off_wd;
      end
      if (clm_we) begin
        clm_a[idx] <= clm_wd;
      end
    end
  end

  // item capture, list position and result registers
  always_ff @(posedge clk) begin
    rd_pos <= rd_pos_next;
    if ((state == shid_pkg::S_IDLE) && start) begin
      mode_r <= mode;
      line_r <= line;
      id_r   <= id_in;
      decl_r <= declined;
    end
    if (fin) begin
      status       <= st_n;
      wake_valid   <= wv_n;
      wake_id      <= wid_n;
      outcome      <= oc_n;
      eoi          <= eoi_n;
      spurious     <= sp_n;
      line_enabled <= le_n;
    end
  end

  // checks
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a preceding busy cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (!wake_valid && !spurious &&
                          (outcome == shid_pkg::OUT_CLAIMED) &&
                          (eoi == shid_pkg::EOI_NONE)))
    else $error("rejected item carries a wake, outcome or eoi");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (busy && line_ok) |-> (cnt_c <= CW'(MAX_HANDLERS)))
    else $error("handler count above list size");

endmodule

// ===== dv/shared_irq_handler_dispatch_checker.sv =====
// ----------------------------------------------------------------------------
// shared_irq_handler_dispatch_checker
// Watches the command, result and config ports of the dispatcher, keeps its
// own copy of every line's handler list, decline offset, last claimer and
// enable bit, predicts the result of each accepted item and compares the
// results field by field, in order. Hands the failure count to the bench.
// ----------------------------------------------------------------------------
module shared_irq_handler_dispatch_checker #(
  parameter int LINES        = 24,
  parameter int MAX_HANDLERS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  logic       cfg_write,
  input  logic       cfg_data,
  input  logic [2:0] mode,
  input  logic [4:0] line,
  input  logic [7:0] handler_id,
  input  logic       declined,
  input  logic       done,
  input  logic       status,
  input  logic       wake_valid,
  input  logic [7:0] wake_id,
  input  logic [1:0] outcome,
  input  logic [1:0] eoi,
  input  logic       spurious,
  input  logic       line_enabled,
  input  logic       wrap_up,
  output int         fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       status;
    logic       wake_valid;
    logic [7:0] wake_id;
    logic [1:0] outcome;
    logic [1:0] eoi;
    logic       spurious;
    logic       line_enabled;
  } dispatch_result_t;

  // per-line dispatcher state
  logic [7:0]       hlist   [LINES][MAX_HANDLERS];
  logic [3:0]       hcount  [LINES];
  logic [3:0]       offs    [LINES];
  logic [2:0]       claimer [LINES];
  logic [LINES-1:0] on_mask;
  logic             apic_on;

  dispatch_result_t pending_results[$];
  int mismatches = 0;
  int leftover   = 0;
  bit wrapped    = 0;

  assign fail_count = mismatches + leftover;

  // expected result of one item, updating the per-line state
  function automatic dispatch_result_t predict_dispatch(input logic [2:0] md,
      input logic [4:0] ln, input logic [7:0] id, input logic dec);
    dispatch_result_t r;
    int cnt;
    int pos;
    int i;
    r = '0;
    r.status = 1'b1;
    if (ln < LINES && md <= shid_pkg::MODE_COMPLETE) begin
      cnt = hcount[ln];
      case (md)
        shid_pkg::MODE_RAISE: begin
          r.status = 1'b0;
          // timer line only gets its end-of-interrupt
          if (ln == shid_pkg::TIMER_LINE) begin
            r.eoi = apic_on ? shid_pkg::EOI_APIC : shid_pkg::EOI_MASTER;
          end else begin
            offs[ln] = '0;
            if (cnt == 0) begin
              r.spurious = 1'b1;
            end else begin
              r.wake_valid = 1'b1;
              r.wake_id = hlist[ln][int'(claimer[ln]) % cnt];
            end
          end
        end
        shid_pkg::MODE_ATTACH: begin
          if (cnt < MAX_HANDLERS) begin
            hlist[ln][cnt] = id;
            hcount[ln] = 4'(cnt + 1);
            if (cnt == 0) on_mask[ln] = 1'b1;
            r.status = 1'b0;
          end
        end
        shid_pkg::MODE_DETACH: begin
          // first matching entry, then compact the list
          pos = cnt;
          for (i = cnt - 1; i >= 0; i--) begin
            if (hlist[ln][i] == id) pos = i;
          end
          if (pos < cnt) begin
            for (i = pos; i < cnt - 1; i++) hlist[ln][i] = hlist[ln][i + 1];
            cnt = cnt - 1;
            hcount[ln] = 4'(cnt);
            if (offs[ln] >= cnt && offs[ln] > 0) offs[ln] = offs[ln] - 4'd1;
            if (claimer[ln] >= cnt && claimer[ln] > 0) claimer[ln] = claimer[ln] - 3'd1;
            if (cnt == 0) on_mask[ln] = 1'b0;
            r.status = 1'b0;
          end
        end
        shid_pkg::MODE_ACK: begin
          if (cnt != 0) begin
            pos = (int'(offs[ln]) + int'(claimer[ln])) % cnt;
            if (hlist[ln][pos] == id) begin
              if (apic_on) r.eoi = shid_pkg::EOI_APIC;
              else r.eoi = (ln > shid_pkg::LAST_MASTER) ? shid_pkg::EOI_BOTH
                                                        : shid_pkg::EOI_MASTER;
              r.status = 1'b0;
            end
          end
        end
        shid_pkg::MODE_COMPLETE: begin
          if (cnt != 0) begin
            pos = (int'(offs[ln]) + int'(claimer[ln])) % cnt;
            if (hlist[ln][pos] == id) begin
              r.status = 1'b0;
              if (!dec) begin
                claimer[ln] = 3'(pos);
                r.outcome = shid_pkg::OUT_CLAIMED;
              end else begin
                // decline: move round robin until everyone has passed
                if (offs[ln] < MAX_HANDLERS) offs[ln] = offs[ln] + 4'd1;
                if (offs[ln] < cnt) begin
                  r.wake_valid = 1'b1;
                  r.wake_id = hlist[ln][(pos + 1) % cnt];
                  r.outcome = shid_pkg::OUT_PASSED;
                end else begin
                  r.outcome = shid_pkg::OUT_DECLINED;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
    r.line_enabled = (ln < LINES) ? on_mask[ln] : 1'b0;
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // watch the ports at every edge
  always @(posedge clk) begin
    dispatch_result_t want;
    if (rst) begin
      for (int k = 0; k < LINES; k++) begin
        hcount[k]  = '0;
        offs[k]    = '0;
        claimer[k] = '0;
      end
      on_mask = '0;
      on_mask[shid_pkg::CASCADE_LINE] = 1'b1;
      apic_on = 1'b0;
      pending_results.delete();
    end else begin
      if (done) begin
        if (pending_results.size() == 0) begin
          $error("result with no item outstanding");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", want.status, status);
          check_field("wake_valid", want.wake_valid, wake_valid);
          check_field("wake_id", want.wake_id, wake_id);
          check_field("outcome", want.outcome, outcome);
          check_field("eoi", want.eoi, eoi);
          check_field("spurious", want.spurious, spurious);
          check_field("line_enabled", want.line_enabled, line_enabled);
        end
      end
      if (start && !busy) begin
        pending_results.push_back(predict_dispatch(mode, line, handler_id, declined));
      end
      if (cfg_write) apic_on = cfg_data;
      // results still owed at the end of the run
      if (wrap_up && !wrapped) begin
        wrapped = 1'b1;
        leftover = pending_results.size();
        if (leftover != 0) $error("%0d results never arrived", leftover);
      end
    end
  end

endmodule

// ===== dv/shared_irq_handler_dispatch_core_tb.sv =====
// ----------------------------------------------------------------------------
// shared_irq_handler_dispatch_core_tb
// Drives the dispatcher with a directed set of corner items, then with random
// attach/detach churn, interrupt episodes (raise, acknowledge, claim or decline
// round robin, repeated declines) and noise, over three sender idling phases
// and both end-of-interrupt styles. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module shared_irq_handler_dispatch_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINES            = 24;
  localparam int MAX_HANDLERS     = 8;
  localparam int RANDOM_PER_PHASE = 340;
  localparam int QUIET_LIMIT      = 3000;
  localparam int DRAIN_CYCLES     = 40;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic       cfg_write = 1'b0;
  logic       cfg_data = 1'b0;
  logic [2:0] mode = shid_pkg::MODE_RAISE;
  logic [4:0] line = '0;
  logic [7:0] handler_id = '0;
  logic       declined = 1'b0;
  logic       done;
  logic       status;
  logic       wake_valid;
  logic [7:0] wake_id;
  logic [1:0] outcome;
  logic [1:0] eoi;
  logic       spurious;
  logic       line_enabled;
  logic       wrap_up = 1'b0;
  int         fail_count;

  // handshake bookkeeping and the last result seen
  int         n_acc = 0;
  int         n_done = 0;
  int         quiet = 0;
  int         n_wakes = 0;
  int         n_all_dec = 0;
  int         n_spur = 0;
  int         n_rej = 0;
  logic       got_status;
  logic       got_wake_valid;
  logic [7:0] got_wake_id;
  logic [1:0] got_outcome;

  // stimulus knobs
  int         n_issued = 0;
  int         gap_pct = 16;
  int         member_ops = 0;
  bit         grow = 1'b1;
  logic [7:0] id_pool [6];

  shared_irq_handler_dispatch_core #(
    .LINES(LINES),
    .MAX_HANDLERS(MAX_HANDLERS),
    .ID_BITS(8)
  ) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .mode(mode), .line(line), .handler_id(handler_id), .declined(declined),
    .done(done), .status(status), .wake_valid(wake_valid), .wake_id(wake_id),
    .outcome(outcome), .eoi(eoi), .spurious(spurious), .line_enabled(line_enabled)
  );

  shared_irq_handler_dispatch_checker #(
    .LINES(LINES),
    .MAX_HANDLERS(MAX_HANDLERS)
  ) u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .mode(mode), .line(line), .handler_id(handler_id), .declined(declined),
    .done(done), .status(status), .wake_valid(wake_valid), .wake_id(wake_id),
    .outcome(outcome), .eoi(eoi), .spurious(spurious), .line_enabled(line_enabled),
    .wrap_up(wrap_up), .fail_count(fail_count)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // count handshakes, keep the last result, watchdog on silence
  always @(posedge clk) begin
    if (rst) begin
      n_acc  <= 0;
      n_done <= 0;
      quiet  <= 0;
    end else begin
      if (start && !busy) n_acc <= n_acc + 1;
      if (done) begin
        n_done         <= n_done + 1;
        got_status     <= status;
        got_wake_valid <= wake_valid;
        got_wake_id    <= wake_id;
        got_outcome    <= outcome;
        if (wake_valid) n_wakes <= n_wakes + 1;
        if (!status && outcome == shid_pkg::OUT_DECLINED) n_all_dec <= n_all_dec + 1;
        if (spurious) n_spur <= n_spur + 1;
        if (status) n_rej <= n_rej + 1;
      end
      if ((start && !busy) || done) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("FAIL shared_irq_handler_dispatch_core");
        $finish;
      end
    end
  end

  // one item: random hold-off, offer, wait until busy falls, then drop start
  task automatic issue(input logic [2:0] m, input logic [4:0] l, input logic [7:0] id,
                       input logic d);
    while ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    mode       <= m;
    line       <= l;
    handler_id <= id;
    declined   <= d;
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
    n_issued++;
    @(posedge clk);
  endtask

  task automatic await_result();
    while (n_done != n_acc) @(posedge clk);
  endtask

  // register write with the block idle
  task automatic set_apic(input logic v);
    while (n_done != n_acc || busy) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [4:0] pick_line();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 5'($urandom_range(LINES, 31));
    if (r < 65) begin
      // hot lines: cascade, last master line, first slave line, last line
      case ($urandom_range(0, 3))
        0: return 5'(shid_pkg::CASCADE_LINE);
        1: return shid_pkg::LAST_MASTER;
        2: return shid_pkg::LAST_MASTER + 5'd1;
        default: return 5'(LINES - 1);
      endcase
    end
    return 5'($urandom_range(0, LINES - 1));
  endfunction

  function automatic logic [7:0] pick_id();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    return id_pool[$urandom_range(0, 5)];
  endfunction

  // attach or detach, leaning toward filling or draining the lists
  task automatic churn_member();
    logic [4:0] l;
    logic [7:0] id;
    l  = pick_line();
    id = pick_id();
    if ($urandom_range(0, 99) < (grow ? 70 : 30)) issue(shid_pkg::MODE_ATTACH, l, id, 1'b0);
    else issue(shid_pkg::MODE_DETACH, l, id, 1'b0);
    member_ops++;
    if (member_ops % 90 == 0) grow = !grow;
  endtask

  // raise, then let the woken handlers acknowledge and claim or decline
  task automatic run_interrupt();
    logic [4:0] l;
    logic [7:0] cur;
    logic [7:0] first_woken;
    logic [7:0] id;
    logic       dec;
    l = pick_line();
    issue(shid_pkg::MODE_RAISE, l, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    await_result();
    if (!got_wake_valid) return;
    cur = got_wake_id;
    first_woken = cur;
    for (int step = 0; step < 12; step++) begin
      if ($urandom_range(0, 3) == 0) begin
        id = ($urandom_range(0, 7) == 0) ? cur ^ 8'($urandom_range(1, 255)) : cur;
        issue(shid_pkg::MODE_ACK, l, id, 1'($urandom_range(0, 1)));
      end
      id  = ($urandom_range(0, 15) == 0) ? cur ^ 8'($urandom_range(1, 255)) : cur;
      dec = ($urandom_range(0, 99) < 60);
      issue(shid_pkg::MODE_COMPLETE, l, id, dec);
      await_result();
      if (got_status) return;
      if (got_outcome == shid_pkg::OUT_CLAIMED) return;
      if (got_outcome == shid_pkg::OUT_PASSED) begin
        cur = got_wake_id;
      end else begin
        // all declined: the first woken handler is current again
        if ($urandom_range(0, 1) == 0) return;
        cur = first_woken;
      end
    end
  endtask

  initial begin
    int base;
    int r;
    id_pool[0] = 8'h00;
    id_pool[1] = 8'hFF;
    for (int k = 2; k < 6; k++) id_pool[k] = 8'($urandom_range(0, 255));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners, 8259 style
    gap_pct = 16;
    set_apic(1'b0);
    issue(shid_pkg::MODE_RAISE, shid_pkg::TIMER_LINE, 8'h00, 1'b0);
    issue(shid_pkg::MODE_RAISE, 5'd5, 8'hFF, 1'b1);
    issue(shid_pkg::MODE_RAISE, 5'(shid_pkg::CASCADE_LINE), 8'h00, 1'b0);
    issue(shid_pkg::MODE_DETACH, 5'(shid_pkg::CASCADE_LINE), 8'h01, 1'b0);
    issue(shid_pkg::MODE_ACK, 5'd3, 8'h00, 1'b0);
    issue(shid_pkg::MODE_COMPLETE, 5'd3, 8'h00, 1'b1);
    issue(shid_pkg::MODE_RAISE, 5'(LINES), 8'h00, 1'b0);
    issue(shid_pkg::MODE_ATTACH, 5'd31, 8'hFF, 1'b1);
    issue(shid_pkg::MODE_COMPLETE + 3'd3, 5'd4, 8'h00, 1'b0);
    issue(shid_pkg::MODE_COMPLETE + 3'd1, 5'd4, 8'h00, 1'b0);
    // fill line 9, with a duplicate identity, then overflow it
    issue(shid_pkg::MODE_ATTACH, 5'd9, 8'h00, 1'b0);
    issue(shid_pkg::MODE_ATTACH, 5'd9, 8'hFF, 1'b0);
    issue(shid_pkg::MODE_ATTACH, 5'd9, 8'hAA, 1'b0);
    issue(shid_pkg::MODE_ATTACH, 5'd9, 8'h55, 1'b0);
    issue(shid_pkg::MODE_ATTACH, 5'd9, 8'hFF, 1'b0);
    issue(shid_pkg::MODE_ATTACH, 5'd9, 8'h01, 1'b0);
    issue(shid_pkg::MODE_ATTACH, 5'd9, 8'h80, 1'b0);
    issue(shid_pkg::MODE_ATTACH, 5'd9, 8'h7F, 1'b0);
    issue(shid_pkg::MODE_ATTACH, 5'd9, 8'h12, 1'b0);
    // raise, wrong and right acknowledge, decline then claim
    issue(shid_pkg::MODE_RAISE, 5'd9, 8'h00, 1'b0);
    issue(shid_pkg::MODE_ACK, 5'd9, 8'hFF, 1'b0);
    issue(shid_pkg::MODE_ACK, 5'd9, 8'h00, 1'b0);
    issue(shid_pkg::MODE_COMPLETE, 5'd9, 8'h00, 1'b1);
    issue(shid_pkg::MODE_COMPLETE, 5'd9, 8'hFF, 1'b0);
    // detach the first duplicate, detach a stranger
    issue(shid_pkg::MODE_DETACH, 5'd9, 8'hFF, 1'b0);
    issue(shid_pkg::MODE_DETACH, 5'd9, 8'h33, 1'b0);
    // last handler leaving the cascade line disables it
    issue(shid_pkg::MODE_ATTACH, 5'(shid_pkg::CASCADE_LINE), 8'h42, 1'b0);
    issue(shid_pkg::MODE_DETACH, 5'(shid_pkg::CASCADE_LINE), 8'h42, 1'b0);
    base = n_issued;

    // random phases: sender idling 16, 64, then 0 percent
    for (int p = 0; p < 3; p++) begin
      gap_pct = (p == 0) ? 16 : (p == 1) ? 64 : 0;
      set_apic(p != 1);
      while (n_issued < base + (p + 1) * RANDOM_PER_PHASE) begin
        r = $urandom_range(0, 99);
        if (r < 40) run_interrupt();
        else if (r < 80) churn_member();
        else issue(3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
                   8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end

    // drain, settle, collect the verdict
    await_result();
    repeat (DRAIN_CYCLES) @(posedge clk);
    wrap_up <= 1'b1;
    repeat (2) @(posedge clk);
    $display("covered %0d items: %0d wakes, %0d all-declined, %0d spurious, %0d rejected",
             n_acc, n_wakes, n_all_dec, n_spur, n_rej);
    $display("end-of-interrupt style 8259, APIC, 8259, APIC; sender idling 16/64/0 percent");
    if (fail_count == 0) begin
      $display("PASS shared_irq_handler_dispatch_core");
    end else begin
      $display("FAIL shared_irq_handler_dispatch_core");
    end
    $finish;
  end

endmodule
